// ----- sv/pal_pkg.sv -----
package pal_pkg;

  localparam int LIST_CAPACITY   = 64;
  localparam int LIST_DATA_WIDTH = 32;

  // Fixed field widths of the request and result transactions.
  localparam int KIND_W     = 3;
  localparam int POS_W      = 7;
  localparam int OUT_DATA_W = 32;
  localparam int COUNT_W    = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_GET    = 3'd2,
    KIND_SET    = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_WR,
    ST_GET_CAP,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic idx_init;
    logic idx_step;
    logic rd_shift;
    logic wr_shift;
    logic wr_pos;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic ok_set;
    logic rd_capture;
    logic res_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_t kind;
    logic  ins_ok;
    logic  in_list;
    logic  ins_nomove;
    logic  rem_nomove;
    logic  shift_last;
    logic  out_free;
  } dp_status_t;

endpackage

// ----- sv/pal_ram.sv -----
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pal_ctl.sv -----
module pal_ctl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pal_pkg::dp_status_t status,
  output pal_pkg::ctl_cmd_t   cmd
);

  pal_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pal_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      pal_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = pal_pkg::ST_EXEC;
        end
      end
      pal_pkg::ST_EXEC: begin
        state_next = pal_pkg::ST_RESP;
        case (status.kind)
          pal_pkg::KIND_INSERT: begin
            if (status.ins_ok) begin
              cmd.ok_set   = 1'b1;
              cmd.idx_init = 1'b1;
              state_next   = status.ins_nomove ? pal_pkg::ST_INS_WR : pal_pkg::ST_SH_RD;
            end
          end
          pal_pkg::KIND_REMOVE: begin
            if (status.in_list) begin
              cmd.ok_set   = 1'b1;
              cmd.idx_init = 1'b1;
              if (status.rem_nomove) begin
                cmd.cnt_dec = 1'b1;
              end else begin
                state_next = pal_pkg::ST_SH_RD;
              end
            end
          end
          pal_pkg::KIND_GET: begin
            if (status.in_list) begin
              cmd.ok_set = 1'b1;
              state_next = pal_pkg::ST_GET_CAP;
            end
          end
          pal_pkg::KIND_SET: begin
            if (status.in_list) begin
              cmd.ok_set = 1'b1;
              cmd.wr_pos = 1'b1;
            end
          end
          pal_pkg::KIND_CLEAR: begin
            cmd.ok_set  = 1'b1;
            cmd.cnt_clr = 1'b1;
          end
          default: begin
            state_next = pal_pkg::ST_RESP;
          end
        endcase
      end
      pal_pkg::ST_SH_RD: begin
        cmd.rd_shift = 1'b1;
        state_next   = pal_pkg::ST_SH_WR;
      end
      pal_pkg::ST_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_step = 1'b1;
        if (!status.shift_last) begin
          state_next = pal_pkg::ST_SH_RD;
        end else if (status.kind == pal_pkg::KIND_INSERT) begin
          state_next = pal_pkg::ST_INS_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = pal_pkg::ST_RESP;
        end
      end
      pal_pkg::ST_INS_WR: begin
        cmd.wr_pos  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = pal_pkg::ST_RESP;
      end
      pal_pkg::ST_GET_CAP: begin
        cmd.rd_capture = 1'b1;
        state_next     = pal_pkg::ST_RESP;
      end
      pal_pkg::ST_RESP: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = pal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pal_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/pal_dp.sv -----
module pal_dp #(
  parameter int CAPACITY   = pal_pkg::LIST_CAPACITY,
  parameter int DATA_WIDTH = pal_pkg::LIST_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pal_pkg::ctl_cmd_t                   cmd,
  output pal_pkg::dp_status_t                 status,
  input  logic [pal_pkg::KIND_W-1:0]          in_kind,
  input  logic [pal_pkg::POS_W-1:0]           in_pos,
  input  logic [DATA_WIDTH-1:0]               in_word,
  output logic                                ram_we,
  output logic [$clog2(CAPACITY)-1:0]         ram_waddr,
  output logic [DATA_WIDTH-1:0]               ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]         ram_raddr,
  input  logic [DATA_WIDTH-1:0]               ram_rdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_ok,
  output logic [pal_pkg::OUT_DATA_W-1:0]      out_data,
  output logic [pal_pkg::COUNT_W-1:0]         out_count,
  output logic                                out_empty
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;

  pal_pkg::kind_t               req_kind;
  logic [pal_pkg::POS_W-1:0]    req_pos;
  logic [DATA_WIDTH-1:0]        req_word;
  logic [AW-1:0]                idx, idx_next;
  logic [CW-1:0]                count;
  logic                         res_ok;
  logic [DATA_WIDTH-1:0]        res_data;
  logic [pal_pkg::OUT_DATA_W-1:0] res_data_ext;
  logic [pal_pkg::COUNT_W-1:0]  count_ext;

  logic [CMPW-1:0] pos_e, cnt_e, idx_e;
  logic [AW-1:0]   pos_addr;
  logic            is_ins;

  assign pos_e    = CMPW'(req_pos);
  assign cnt_e    = CMPW'(count);
  assign idx_e    = CMPW'(idx);
  assign pos_addr = AW'(pos_e - CMPW'(1));
  assign is_ins   = (req_kind == pal_pkg::KIND_INSERT);

  assign status.kind       = req_kind;
  assign status.ins_ok     = (pos_e != '0) && (pos_e <= cnt_e + CMPW'(1))
                             && (cnt_e < CMPW'(CAPACITY));
  assign status.in_list    = (pos_e != '0) && (pos_e <= cnt_e);
  assign status.ins_nomove = (pos_e - CMPW'(1) == cnt_e);
  assign status.rem_nomove = (pos_e == cnt_e);
  assign status.shift_last = is_ins ? (idx_e == pos_e) : (idx_e + CMPW'(2) == cnt_e);
  assign status.out_free   = !out_valid || out_ready;

  // Insert walks downwards from the tail, remove walks upwards from the hole.
  assign idx_next  = is_ins ? idx - AW'(1) : idx + AW'(1);
  assign ram_raddr = cmd.rd_shift ? idx_next : pos_addr;
  assign ram_we    = cmd.wr_shift || cmd.wr_pos;
  assign ram_waddr = cmd.wr_shift ? idx : pos_addr;
  assign ram_wdata = cmd.wr_shift ? ram_rdata : req_word;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= pal_pkg::kind_t'(in_kind);
      req_pos  <= in_pos;
      req_word <= in_word;
      res_ok   <= 1'b0;
      res_data <= '0;
    end else begin
      if (cmd.ok_set) begin
        res_ok <= 1'b1;
      end
      if (cmd.rd_capture) begin
        res_data <= ram_rdata;
      end
    end
    if (cmd.idx_init) begin
      idx <= is_ins ? AW'(count) : pos_addr;
    end else if (cmd.idx_step) begin
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  if (DATA_WIDTH >= pal_pkg::OUT_DATA_W) begin : g_data_cut
    assign res_data_ext = res_data[pal_pkg::OUT_DATA_W-1:0];
  end else begin : g_data_ext
    assign res_data_ext = {{(pal_pkg::OUT_DATA_W - DATA_WIDTH){1'b0}}, res_data};
  end

  if (CW >= pal_pkg::COUNT_W) begin : g_cnt_cut
    assign count_ext = count[pal_pkg::COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign count_ext = {{(pal_pkg::COUNT_W - CW){1'b0}}, count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_ok    <= res_ok;
      out_data  <= res_data_ext;
      out_count <= count_ext;
      out_empty <= (count == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_e <= CMPW'(CAPACITY))
    else $error("list length beyond capacity");

  a_inc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> (cnt_e < CMPW'(CAPACITY)))
    else $error("insert committed on a full list");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_shift && cmd.wr_pos))
    else $error("two store writes in one cycle");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

endmodule

// ----- sv/positional_array_list.sv -----
// Positional list of up to CAPACITY words with 1-based positions.
// Requests arrive on the s_axis channel: tuser carries the request kind
// (insert, remove, get, set, clear) and tdata carries the position and word.
// One result transaction leaves on m_axis for every request: ok, the word
// read by a get (zero otherwise), the length afterwards and an empty flag.
// Requests are handled one at a time by a controller stepping a datapath
// that holds the words in a RAM with a registered read port. A set, clear
// or rejected request passes the EXEC and RESP states before m_axis_tvalid
// rises, and a get passes EXEC, GET_CAP and RESP. Insert at position p on a
// list of n words moves n-p+1 words and remove moves n-p words; each move is
// a RAM read (SH_RD) followed by a write (SH_WR), and insert then writes
// the new word (INS_WR) after the moves. The next request is taken the
// cycle after the result is loaded.
// A result waiting in the output register does not hold up the next
// request; only a second result waits while the receiver stalls.
// Reset empties the list and drops any pending result; the stored words
// are left as they are and are never read before being written again.
module positional_array_list #(
  parameter int CAPACITY   = pal_pkg::LIST_CAPACITY,
  parameter int DATA_WIDTH = pal_pkg::LIST_DATA_WIDTH
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             s_axis_tvalid,
  output logic                                             s_axis_tready,
  // position [6:0], data_in [DATA_WIDTH+6:7], zero padded to whole bytes
  input  logic [((pal_pkg::POS_W + DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // kind [2:0]
  input  logic [pal_pkg::KIND_W-1:0]                       s_axis_tuser,
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  // ok [0], data_out [32:1], count [39:33], empty_res [40], zero padded
  output logic [47:0]                                      m_axis_tdata
);

  localparam int AW = $clog2(CAPACITY);

  pal_pkg::ctl_cmd_t   cmd;
  pal_pkg::dp_status_t status;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [AW-1:0]                   ram_raddr;
  logic [DATA_WIDTH-1:0]           ram_wdata;
  logic [DATA_WIDTH-1:0]           ram_rdata;
  logic                            res_ok;
  logic                            res_empty;
  logic [pal_pkg::OUT_DATA_W-1:0]  res_data;
  logic [pal_pkg::COUNT_W-1:0]     res_count;

  // The controller sequences each request; it sees only s_axis_tvalid and the status bits.
  pal_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the request, the length, the walking index and the
  // output register.
  pal_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_kind   (s_axis_tuser),
    .in_pos    (s_axis_tdata[pal_pkg::POS_W-1:0]),
    .in_word   (s_axis_tdata[pal_pkg::POS_W +: DATA_WIDTH]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_ok    (res_ok),
    .out_data  (res_data),
    .out_count (res_count),
    .out_empty (res_empty)
  );

  // Word storage; a shift moves one word per read and write pair.
  pal_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign m_axis_tdata = {7'd0, res_empty, res_count, res_data, res_ok};

endmodule
